// ===== rtl/tla_pkg.sv =====
// Package of the text line annotator: configuration and descriptor types,
// register indexes and character codes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tla_pkg;

  // Register indexes on the configuration port.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_SQUEEZE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUMBER   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENDS     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TABS     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NONPRINT = 3'd4;
  localparam int CfgDataW = 2;

  // Numbering modes. The code left over behaves as no numbering.
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONBLANK = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_FIRST_PRINT = 8'd32;
  localparam logic [7:0] CARET_OFFSET   = 8'd64;
  localparam logic [7:0] HIGH_FIRST     = 8'd128;
  localparam logic [7:0] LOW7_MASK      = 8'h7F;

  // Depth of the descriptor queue between front and back.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef struct packed {
    logic       squeeze_en;
    logic [1:0] number_mode;
    logic       mark_eol;
    logic       caret_tab;
    logic       caret_ctrl;
  } cfg_t;

  // What the back end has to emit for one input byte, apart from the
  // digits of the line number: whether the number and its tab lead,
  // and the one to four bytes of the character itself, first in slot 0.
  typedef struct packed {
    logic            num_en;
    logic [2:0]      char_cnt;
    logic [3:0][7:0] chars;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/tla_front.sv =====
// Front end of the text line annotator: squeezing, line state, numbering
// and character classification. Depends on tla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tla_front
  import tla_pkg::*;
#(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire logic [7:0]                         in_byte_i,
  input  wire cfg_t                               cfg_i,
  output logic                                    job_valid_o,
  output job_t                                    job_o,
  output logic [NUMBER_DIGITS-1:0][7:0]           digits_o
);

  localparam int CountW = 4 * NUMBER_DIGITS;

  logic [CountW-1:0] line_count_q, line_count_d;
  logic              at_start_q, at_start_d;
  logic              prev_nl_q, prev_nl_d;
  logic [1:0]        blank_run_q, blank_run_d;

  logic              is_nl;
  logic              drop;
  logic              num_en;
  logic [CountW-1:0] count_inc;
  logic              all_nines;
  logic              carry;
  logic              started;
  logic [3:0]        digit;
  logic [7:0]        low;
  logic [7:0]        x0, x1;
  logic [2:0]        xn;

  assign is_nl = (in_byte_i == CH_NL);

  // Saturating BCD increment of the line counter.
  always_comb begin
    all_nines = 1'b1;
    carry     = 1'b1;
    count_inc = line_count_q;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      all_nines = all_nines && (line_count_q[4*i +: 4] == 4'd9);
      if (carry) begin
        count_inc[4*i +: 4] = (line_count_q[4*i +: 4] == 4'd9) ? 4'd0
                              : line_count_q[4*i +: 4] + 4'd1;
      end
      carry = carry && (line_count_q[4*i +: 4] == 4'd9);
    end
    if (all_nines) begin
      count_inc = line_count_q;
    end
  end

  // Digits of the current number, most significant first, with leading
  // zeros shown as spaces.
  always_comb begin
    started = 1'b0;
    digit   = '0;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      digit   = line_count_q[4*(NUMBER_DIGITS-1-k) +: 4];
      started = started || (digit != 4'd0) || (k == NUMBER_DIGITS - 1);
      digits_o[k] = started ? (CH_ZERO | {4'd0, digit}) : CH_SPACE;
    end
  end

  always_comb begin
    blank_run_d  = blank_run_q;
    drop         = 1'b0;
    line_count_d = line_count_q;
    at_start_d   = at_start_q;
    prev_nl_d    = prev_nl_q;
    num_en       = 1'b0;
    job_o        = '0;
    low          = in_byte_i & LOW7_MASK;
    x0           = CH_CARET;
    x1           = CH_QMARK;
    xn           = 3'd2;

    // Caret form of the low seven bits.
    if (low == CH_DEL) begin
      x1 = CH_QMARK;
    end else if (low < CH_FIRST_PRINT) begin
      x1 = low + CARET_OFFSET;
    end else begin
      x0 = low;
      xn = 3'd1;
    end

    if (cfg_i.squeeze_en) begin
      if (prev_nl_q && is_nl) begin
        if (blank_run_q < 2'd2) begin
          blank_run_d = blank_run_q + 2'd1;
        end
        drop = (blank_run_d > 2'd1);
      end else begin
        blank_run_d = 2'd0;
      end
    end

    num_en = at_start_q && ((cfg_i.number_mode == NUM_ALL) ||
                            ((cfg_i.number_mode == NUM_NONBLANK) && !is_nl));
    job_o.num_en = num_en;

    priority if ((in_byte_i == CH_TAB) && cfg_i.caret_tab) begin
      job_o.chars    = {8'd0, 8'd0, CH_I, CH_CARET};
      job_o.char_cnt = 3'd2;
    end else if (((in_byte_i < CH_FIRST_PRINT) || (in_byte_i >= CH_DEL)) && !is_nl &&
                 (in_byte_i != CH_TAB) && cfg_i.caret_ctrl) begin
      if (in_byte_i >= HIGH_FIRST) begin
        job_o.chars    = {x1, x0, CH_DASH, CH_M};
        job_o.char_cnt = xn + 3'd2;
      end else begin
        job_o.chars    = {8'd0, 8'd0, x1, x0};
        job_o.char_cnt = xn;
      end
    end else if (is_nl && cfg_i.mark_eol) begin
      job_o.chars    = {8'd0, 8'd0, CH_NL, CH_DOLLAR};
      job_o.char_cnt = 3'd2;
    end else begin
      job_o.chars    = {8'd0, 8'd0, 8'd0, in_byte_i};
      job_o.char_cnt = 3'd1;
    end

    if (!drop) begin
      if (num_en) begin
        line_count_d = count_inc;
      end
      at_start_d = is_nl;
      prev_nl_d  = is_nl;
    end
  end

  assign job_valid_o = accept_i && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= CountW'(1);
      at_start_q   <= 1'b1;
      prev_nl_q    <= 1'b1;
      blank_run_q  <= 2'd0;
    end else if (accept_i) begin
      line_count_q <= line_count_d;
      at_start_q   <= at_start_d;
      prev_nl_q    <= prev_nl_d;
      blank_run_q  <= blank_run_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tla_queue.sv =====
// Short register queue of descriptors between front and back end.
// Depends on tla_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module tla_queue
  import tla_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [QueueDepth-1:0][WIDTH-1:0] mem_q;
  logic [QPtrW-1:0]                 wptr_q, rptr_q;
  logic [QPtrW:0]                   count_q, count_d;

  assign full_o  = (count_q == (QPtrW + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && valid_o)) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i && valid_o) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rptr_q <= rptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tla_back.sv =====
// Back end of the text line annotator: walks the slots of the head
// descriptor, one output word a cycle while the receiver takes them, into
// the output register. Depends on tla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tla_back
  import tla_pkg::*;
#(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          head_valid_i,
  input  wire job_t                          head_job_i,
  input  wire logic [NUMBER_DIGITS-1:0][7:0] head_digits_i,
  output logic                               head_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_pop_i,
  output logic [7:0]                         out_byte_o,
  output logic                               out_last_o
);

  // Slots: the digits, then the tab, then up to four character bytes.
  localparam int SlotW = $clog2(NUMBER_DIGITS + 5);
  localparam logic [SlotW-1:0] TabSlot  = SlotW'(NUMBER_DIGITS);
  localparam logic [SlotW-1:0] CharSlot = SlotW'(NUMBER_DIGITS + 1);

  logic [SlotW-1:0] slot_q, slot_d;
  logic             fresh_q, fresh_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  logic [SlotW-1:0] eff;
  logic [SlotW-1:0] last_slot;
  logic [SlotW-1:0] coff;
  logic             is_last;
  logic             advance;
  logic [7:0]       sel_byte;

  assign eff       = fresh_q ? (head_job_i.num_en ? '0 : CharSlot) : slot_q;
  assign last_slot = TabSlot + SlotW'(head_job_i.char_cnt);
  assign coff      = eff - CharSlot;
  assign is_last   = (eff == last_slot);
  assign advance   = head_valid_i && (!out_valid_q || out_pop_i);
  assign head_pop_o = advance && is_last;

  always_comb begin
    sel_byte = head_job_i.chars[coff[1:0]];
    if (eff == TabSlot) begin
      sel_byte = CH_TAB;
    end
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if (eff == SlotW'(k)) begin
        sel_byte = head_digits_i[k];
      end
    end
  end

  always_comb begin
    slot_d      = slot_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_valid_q && out_pop_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      out_last_d  = is_last;
      if (is_last) begin
        fresh_d = 1'b1;
      end else begin
        fresh_d = 1'b0;
        slot_d  = eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/text_line_annotator.sv =====
// Top level of the text line annotator: configuration registers and the
// front end, descriptor queue and back end. Depends on tla_pkg, tla_front,
// tla_queue and tla_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes a text stream one byte word at a time and gives its
// annotated form one byte word at a time, with last_of_run_o marking the
// final output word caused by each input word. A new input word is taken
// in every cycle while the two-entry descriptor queue has room; full rises
// only when the back end is behind. The back end emits one output word a
// cycle while the receiver takes them, so an input word that expands to k
// output words (up to NUMBER_DIGITS + 5) holds the back end until all k are
// out; with no receiver stall the sustained rate is one output word per
// cycle, set by that slot sequencer. A squeezed blank line is accepted and
// gives no output. With an idle back end an accepted input word goes into
// the queue register, then its first output word into the output register.
// The user writes configuration only while the block is idle; it does not check.
module text_line_annotator
  import tla_pkg::*;
#(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [7:0]          in_byte_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic [7:0]               out_byte_o,
  output logic                     last_of_run_o
);

  localparam int JobW = $bits(job_t) + 8 * NUMBER_DIGITS;

  cfg_t cfg_q, cfg_d;

  // Writes beyond the register list fall through and change nothing.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SQUEEZE:  cfg_d.squeeze_en  = cfg_data_i[0];
        CFG_NUMBER:   cfg_d.number_mode = cfg_data_i[1:0];
        CFG_ENDS:     cfg_d.mark_eol    = cfg_data_i[0];
        CFG_TABS:     cfg_d.caret_tab   = cfg_data_i[0];
        CFG_NONPRINT: cfg_d.caret_ctrl  = cfg_data_i[0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic                          accept;
  logic                          job_valid;
  job_t                          job;
  logic [NUMBER_DIGITS-1:0][7:0] digits;
  logic                          q_full;
  logic                          head_valid;
  logic                          head_pop;
  logic [JobW-1:0]               head_data;
  job_t                          head_job;
  logic [NUMBER_DIGITS-1:0][7:0] head_digits;
  logic                          out_valid;

  assign full   = q_full;
  assign accept = push && !q_full;

  tla_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .cfg_i      (cfg_q),
    .job_valid_o(job_valid),
    .job_o      (job),
    .digits_o   (digits)
  );

  tla_queue #(
    .WIDTH(JobW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_valid),
    .data_i ({job, digits}),
    .full_o (q_full),
    .pop_i  (head_pop),
    .valid_o(head_valid),
    .data_o (head_data)
  );

  assign {head_job, head_digits} = head_data;

  tla_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .head_digits_i(head_digits),
    .head_pop_o   (head_pop),
    .out_valid_o  (out_valid),
    .out_pop_i    (pop),
    .out_byte_o   (out_byte_o),
    .out_last_o   (last_of_run_o)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== rtl/tla_checker.sv =====
// Port-level checks of the text line annotator and their bind to the top
// level. Depends on tla_pkg for character codes.
`timescale 1ns / 1ps
`default_nettype none

module tla_checker
  import tla_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_of_run_o
);

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_of_run_o)))
    else $error("result word changed while waiting");

  // Once reset has been seen at an edge, the block has nothing to deliver
  // and room to accept at the next edge.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("block not idle in reset");

  // The queue fills only behind an occupied output register.
  a_full_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("queue full with output register empty");

  // A newline is always the final word of its run.
  a_nl_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_byte_o == CH_NL)) |-> last_of_run_o)
    else $error("newline not marked as last of run");

endmodule

bind text_line_annotator tla_checker u_tla_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .out_byte_o   (out_byte_o),
  .last_of_run_o(last_of_run_o)
);

`default_nettype wire

// ===== tb/sv/text_line_annotator_chk.sv =====
// Checker of the text line annotator: follows the register writes and the
// word channels, predicts each annotated output word and compares it with
// the block. Depends on tla_pkg.
`timescale 1ns / 1ps

module text_line_annotator_chk
  import tla_pkg::*;
#(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push_i,
  input  logic                full_i,
  input  logic [7:0]          in_byte_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  logic [7:0]          out_byte_i,
  input  logic                last_of_run_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int LineNoW = 4 * NUMBER_DIGITS;
  localparam logic [LineNoW-1:0] LINE_NO_MAX = {NUMBER_DIGITS{4'd9}};
  localparam logic [LineNoW-1:0] LINE_NO_ONE = LineNoW'(1);

  typedef struct packed {
    logic [7:0] data;
    logic       end_of_run;
  } annot_word_t;

  cfg_t               opt;
  logic [LineNoW-1:0] line_no = LINE_NO_ONE;
  logic               at_start = 1'b1;
  logic               after_nl = 1'b1;
  logic [1:0]         blank_cnt = 2'd0;
  annot_word_t        annot_q[$];

  initial begin
    opt        = '0;
    fail_cnt_o = 0;
    pending_o  = 0;
    checked_o  = 0;
  end

  function automatic void push_word(input logic [7:0] b);
    annot_word_t w;
    w.data       = b;
    w.end_of_run = 1'b0;
    annot_q.push_back(w);
  endfunction

  // Works out the output words of one input byte and advances the line state.
  function automatic void annotate_byte(input logic [7:0] ch);
    logic       is_nl;
    logic       lead;
    logic       carry;
    logic [3:0] d;
    logic [7:0] c;
    is_nl = (ch == CH_NL);
    if (opt.squeeze_en) begin
      if (after_nl && is_nl) begin
        if (blank_cnt < 2'd2) blank_cnt = blank_cnt + 2'd1;
        // A second or later empty line in a row vanishes without output.
        if (blank_cnt > 2'd1) return;
      end else begin
        blank_cnt = 2'd0;
      end
    end
    if (at_start && (opt.number_mode == NUM_ALL ||
                     (opt.number_mode == NUM_NONBLANK && !is_nl))) begin
      lead = 1'b0;
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
        d = line_no[4*i +: 4];
        if (d != 4'd0 || i == 0) lead = 1'b1;
        push_word(lead ? CH_ZERO + 8'(d) : CH_SPACE);
      end
      push_word(CH_TAB);
      // BCD increment that sticks at all nines.
      if (line_no != LINE_NO_MAX) begin
        carry = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
          if (carry) begin
            if (line_no[4*i +: 4] == 4'd9) begin
              line_no[4*i +: 4] = 4'd0;
            end else begin
              line_no[4*i +: 4] = line_no[4*i +: 4] + 4'd1;
              carry = 1'b0;
            end
          end
        end
      end
    end
    if (ch == CH_TAB && opt.caret_tab) begin
      push_word(CH_CARET);
      push_word(CH_I);
    end else if ((ch < CH_FIRST_PRINT || ch >= CH_DEL) && !is_nl && ch != CH_TAB &&
                 opt.caret_ctrl) begin
      c = ch;
      if (c >= HIGH_FIRST) begin
        push_word(CH_M);
        push_word(CH_DASH);
        c = c & LOW7_MASK;
      end
      if (c == CH_DEL) begin
        push_word(CH_CARET);
        push_word(CH_QMARK);
      end else if (c < CH_FIRST_PRINT) begin
        push_word(CH_CARET);
        push_word(c + CARET_OFFSET);
      end else begin
        push_word(c);
      end
    end else begin
      if (is_nl && opt.mark_eol) push_word(CH_DOLLAR);
      push_word(ch);
    end
    after_nl = is_nl;
    at_start = is_nl;
    annot_q[annot_q.size() - 1].end_of_run = 1'b1;
  endfunction

  function automatic void note_fail(input string msg);
    if (fail_cnt_o < 10) $display("%0t ns: mismatch: %s", $time, msg);
    fail_cnt_o++;
  endfunction

  function automatic void check_word();
    annot_word_t w;
    if (annot_q.size() == 0) begin
      note_fail($sformatf("unexpected word %h last %b", out_byte_i, last_of_run_i));
    end else begin
      w = annot_q.pop_front();
      if (w.data !== out_byte_i || w.end_of_run !== last_of_run_i)
        note_fail($sformatf("expected word %h last %b, got word %h last %b",
                            w.data, w.end_of_run, out_byte_i, last_of_run_i));
    end
    checked_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt       = '0;
      line_no   = LINE_NO_ONE;
      at_start  = 1'b1;
      after_nl  = 1'b1;
      blank_cnt = 2'd0;
      annot_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SQUEEZE:  opt.squeeze_en  = cfg_data_i[0];
          CFG_NUMBER:   opt.number_mode = cfg_data_i[1:0];
          CFG_ENDS:     opt.mark_eol    = cfg_data_i[0];
          CFG_TABS:     opt.caret_tab   = cfg_data_i[0];
          CFG_NONPRINT: opt.caret_ctrl  = cfg_data_i[0];
          default: ;
        endcase
      end
      // Prediction goes first so that even a same-cycle result would find it.
      if (push_i && !full_i) annotate_byte(in_byte_i);
      if (pop_i && !empty_i) check_word();
    end
    pending_o = annot_q.size();
  end

endmodule

// ===== tb/sv/text_line_annotator_tb.sv =====
// Testbench top of the text line annotator: clock, reset, register writes,
// paced input words and a stalling receiver, with the verdict at the end.
// Depends on tla_pkg, text_line_annotator and text_line_annotator_chk.
`timescale 1ns / 1ps

module text_line_annotator_tb;
  import tla_pkg::*;

  localparam int NumDigits = 6;
  // Words still in flight after the last result: a squeezed newline makes
  // none, so the drain waits out the pipeline before touching registers.
  localparam int DrainCycles = NumDigits + 8;
  localparam int PhaseWords  = 68;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          in_byte = 8'h00;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          out_byte;
  logic                last_of_run;

  int fail_cnt;
  int pending;
  int checked;
  int words_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  int pop_mode = 0;
  int pop_window = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_line_annotator #(
    .NUMBER_DIGITS(NumDigits)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte),
    .last_of_run_o(last_of_run)
  );

  text_line_annotator_chk #(
    .NUMBER_DIGITS(NumDigits)
  ) chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .push_i       (push),
    .full_i       (full),
    .in_byte_i    (in_byte),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_byte_i   (out_byte),
    .last_of_run_i(last_of_run),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // The receiver switches between stall patterns in windows of random
  // length: always ready, coin flips, mostly stalled, and a full stall.
  always @(posedge clk) begin
    if (pop_window == 0) begin
      pop_mode   = $urandom_range(0, 3);
      pop_window = $urandom_range(8, 80);
    end else begin
      pop_window--;
    end
    case (pop_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= ($urandom_range(0, 3) == 0);
      default: pop <= 1'b0;
    endcase
  end

  // The sender runs in bursts. Between bursts push drops for a random
  // number of cycles, and some bursts follow each other with no gap at all.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offers one word and holds it until the block takes it. full is sampled
  // at the falling edge, where it is stable for the coming rising edge.
  task automatic send_word(input logic [7:0] b);
    logic was_full;
    pace_sender();
    push    <= 1'b1;
    in_byte <= b;
    do begin
      @(negedge clk);
      was_full = full;
      @(posedge clk);
    end while (was_full);
    words_sent++;
  endtask

  // Stops the sender and waits until every predicted word has come out.
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Writes all five registers, then pokes the unused indexes with junk,
  // which must leave the settings alone.
  task automatic load_settings(input logic [CfgDataW-1:0] sq, input logic [CfgDataW-1:0] nm,
                               input logic [CfgDataW-1:0] en, input logic [CfgDataW-1:0] tb,
                               input logic [CfgDataW-1:0] np);
    write_reg(CFG_SQUEEZE, sq);
    write_reg(CFG_NUMBER, nm);
    write_reg(CFG_ENDS, en);
    write_reg(CFG_TABS, tb);
    write_reg(CFG_NONPRINT, np);
    for (int k = int'(CFG_NONPRINT) + 1; k < (1 << CfgIdxW); k++)
      write_reg(CfgIdxW'(k), CfgDataW'($urandom_range(0, 3)));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly printable text, with tabs, control bytes, DEL and high bytes mixed in.
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 15))
      0:       return CH_TAB;
      1:       return 8'($urandom_range(0, 31));
      2:       return 8'($urandom_range(128, 255));
      3:       return CH_DEL;
      4:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(int'(CH_FIRST_PRINT), int'(CH_DEL) - 1));
    endcase
  endfunction

  // One line of text ended by a newline. Empty lines come often so that
  // runs of blank lines build up for squeezing and numbering.
  task automatic send_line();
    int len;
    len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
    for (int k = 0; k < len; k++) send_word(text_byte());
    send_word(CH_NL);
  endtask

  initial begin
    int quota;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: every byte passes through unchanged.
    send_word("a");
    send_word(8'h00);
    send_word(8'hFF);
    send_word(CH_TAB);
    send_word(CH_NL);
    drain();

    // Every option on. The leading newlines form a blank run: the first is
    // numbered, the rest are squeezed away. Then the edges of caret and M-
    // notation, both ends of the printable range, a tab and a short line.
    load_settings(2'b01, NUM_ALL, 2'b01, 2'b01, 2'b01);
    send_word(CH_NL);
    send_word(CH_NL);
    send_word(CH_NL);
    send_word(8'h00);
    send_word(8'h1F);
    send_word(CH_DEL);
    send_word(8'h80);
    send_word(8'h9F);
    send_word(8'hFF);
    send_word(8'hA0);
    send_word(CH_SPACE);
    send_word("~");
    send_word(CH_TAB);
    send_word(CH_NL);
    drain();

    // Non-blank numbering with squeezing off: the empty line gets no number
    // and the squeeze counter must hold its value.
    load_settings(2'b00, NUM_NONBLANK, 2'b00, 2'b00, 2'b00);
    send_word(CH_NL);
    send_word("y");
    send_word(CH_NL);
    drain();

    // The reserved numbering code, written with every data bit high.
    load_settings(2'b11, 2'b11, 2'b11, 2'b11, 2'b11);
    send_word("z");
    send_word(CH_NL);

    // Random text under several settings, the all-low and all-high ones
    // among them. The counter limit of all nines is far out of reach here.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: load_settings('0, '0, '0, '0, '0);
        1: load_settings('1, '1, '1, '1, '1);
        2: load_settings(2'b01, NUM_ALL, 2'b01, 2'b00, 2'b01);
        3: load_settings(2'b01, NUM_NONBLANK, 2'b00, 2'b01, 2'b00);
        default: load_settings(CfgDataW'($urandom_range(0, 3)), CfgDataW'($urandom_range(0, 3)),
                               CfgDataW'($urandom_range(0, 3)), CfgDataW'($urandom_range(0, 3)),
                               CfgDataW'($urandom_range(0, 3)));
      endcase
      quota = words_sent + PhaseWords;
      while (words_sent < quota) begin
        if ($urandom_range(0, 7) == 0) send_word(8'($urandom_range(0, 255)));
        else send_line();
      end
    end
    drain();

    $display("Summary: %0d input words sent, %0d output words checked.", words_sent, checked);
    $display("Summary: %0d register settings, from all options off to all on.",
             settings_used);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS text_line_annotator");
    end else begin
      $display("%0d mismatches, %0d words still expected.", fail_cnt, pending);
      $display("FAIL text_line_annotator");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #10ms;
    $display("Timeout with %0d words still expected.", pending);
    $display("FAIL text_line_annotator");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tla_pkg.sv
rtl/tla_front.sv
rtl/tla_queue.sv
rtl/tla_back.sv
rtl/text_line_annotator.sv
rtl/tla_checker.sv
tb/sv/text_line_annotator_chk.sv
tb/sv/text_line_annotator_tb.sv
